/* rtl/alf_pkg.sv */
// alf_pkg: shared types and constants for the actuator lease failsafe
// used by every module of the block and by the checker; no dependencies
package alf_pkg;

  localparam int          SLOT_COUNT_DEF  = 10;
  localparam logic [31:0] LEASE_LIMIT_RST = 32'd10000;
  localparam logic [31:0] SEQ_RST         = 32'd1;

  localparam logic [2:0] OP_SET_OUTPUT = 3'd0;
  localparam logic [2:0] OP_HEARTBEAT  = 3'd1;
  localparam logic [2:0] OP_NETWORK_OFF = 3'd2;
  localparam logic [2:0] OP_OTA_OFF    = 3'd3;
  localparam logic [2:0] OP_IDLE       = 3'd4;

  typedef enum logic [2:0] {
    RSN_READY      = 3'd0,
    RSN_COMMAND    = 3'd1,
    RSN_HEARTBEAT  = 3'd2,
    RSN_NET_OFF    = 3'd3,
    RSN_OTA_OFF    = 3'd4,
    RSN_LEASE_LOST = 3'd5
  } reason_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        now_ms;
    logic [31:0]        created_ms;
    logic [31:0]        ttl_ms;
    logic [7:0]         target_index;
    logic signed [15:0] set_value;
    logic               apply_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         slot_index;
    logic signed [15:0] slot_value;
    logic               all_outputs_off;
    logic               lease_active_out;
    logic [31:0]        snapshot_sequence;
    reason_t            reason_code;
    logic               end_of_snapshot;
    logic               end_of_item;
  } out_item_t;

  typedef struct packed {
    logic        all_off;
    logic        lease;
    logic [31:0] seq;
    reason_t     reason;
    logic        twice;
  } snap_ctl_t;

endpackage

/* rtl/alf_core.sv */
// alf_core: input register, lease and slot state, snapshot launch
// depends on alf_pkg
module alf_core import alf_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  in_item_t                    in_item,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        emit_free,
  output logic                        launch,
  output snap_ctl_t                   snap_ctl,
  output logic [SLOT_COUNT-1:0][15:0] snap_slots
);

  logic                        in_valid_r, in_valid_nxt;
  in_item_t                    in_item_r;
  logic [SLOT_COUNT-1:0][15:0] slot_r, slot_nxt;
  logic                        lease_r, lease_nxt;
  logic [31:0]                 last_act_r, last_act_nxt;
  reason_t                     reason_r, reason_nxt;
  logic [31:0]                 seq_r, seq_nxt;
  logic [31:0]                 limit_r;

  logic        accept;
  logic [31:0] age;
  logic [31:0] quiet;
  logic        fresh, do_set, do_hb, do_off, expired;

  assign launch   = in_valid_r && emit_free;
  assign in_stall = in_valid_r && !launch;
  assign accept   = in_valid && !in_stall;
  assign in_valid_nxt = accept || (in_valid_r && !launch);

  assign age   = in_item_r.now_ms - in_item_r.created_ms;
  assign quiet = in_item_r.now_ms - last_act_r;
  assign fresh = (in_item_r.op <= OP_OTA_OFF) && (age <= in_item_r.ttl_ms);
  assign do_set = fresh && (in_item_r.op == OP_SET_OUTPUT) && in_item_r.apply_ok
                  && ({1'b0, in_item_r.target_index} < 9'(SLOT_COUNT));
  assign do_hb  = fresh && (in_item_r.op == OP_HEARTBEAT);
  assign do_off = fresh && ((in_item_r.op == OP_NETWORK_OFF) ||
                            (in_item_r.op == OP_OTA_OFF));
  assign expired = lease_r && !do_set && !do_hb && !do_off && (quiet > limit_r);

  always_comb begin
    slot_nxt     = slot_r;
    lease_nxt    = lease_r;
    last_act_nxt = last_act_r;
    reason_nxt   = reason_r;
    if (do_set) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (in_item_r.target_index == 8'(i)) begin
          slot_nxt[i] = in_item_r.set_value;
        end
      end
      lease_nxt    = 1'b1;
      last_act_nxt = in_item_r.now_ms;
      reason_nxt   = RSN_COMMAND;
    end else if (do_hb) begin
      lease_nxt    = 1'b1;
      last_act_nxt = in_item_r.now_ms;
      reason_nxt   = RSN_HEARTBEAT;
    end else if (do_off) begin
      slot_nxt   = '0;
      lease_nxt  = 1'b0;
      reason_nxt = (in_item_r.op == OP_NETWORK_OFF) ? RSN_NET_OFF : RSN_OTA_OFF;
    end else if (expired) begin
      slot_nxt   = '0;
      lease_nxt  = 1'b0;
      reason_nxt = RSN_LEASE_LOST;
    end
    seq_nxt = seq_r + (do_off ? 32'd2 : 32'd1);
  end

  always_comb begin
    snap_ctl.all_off = ~|slot_nxt;
    snap_ctl.lease   = lease_nxt;
    snap_ctl.seq     = seq_r + 32'd1;
    snap_ctl.reason  = reason_nxt;
    snap_ctl.twice   = do_off;
    snap_slots       = slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      slot_r     <= '0;
      lease_r    <= 1'b0;
      last_act_r <= '0;
      reason_r   <= RSN_READY;
      seq_r      <= SEQ_RST;
      limit_r    <= LEASE_LIMIT_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (launch) begin
        slot_r     <= slot_nxt;
        lease_r    <= lease_nxt;
        last_act_r <= last_act_nxt;
        reason_r   <= reason_nxt;
        seq_r      <= seq_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

endmodule

/* rtl/alf_emit.sv */
// alf_emit: snapshot copy, slot walker and output register
// depends on alf_pkg
module alf_emit import alf_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        launch,
  input  snap_ctl_t                   snap_ctl,
  input  logic [SLOT_COUNT-1:0][15:0] snap_slots,
  output logic                        emit_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output out_item_t                   out_item
);

  logic                        busy_r, busy_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  snap_ctl_t                   ctl_r, ctl_nxt;
  logic [SLOT_COUNT-1:0][15:0] slots_r;
  logic                        out_valid_r;
  out_item_t                   out_item_r, cur_item;
  logic                        out_load, adv, last;

  assign out_load  = !out_valid_r || !out_stall;
  assign adv       = busy_r && out_load;
  assign last      = (idx_r == IDX_W'(SLOT_COUNT - 1));
  assign emit_free = !busy_r || (adv && last && !ctl_r.twice);

  always_comb begin
    cur_item.slot_index        = 4'(idx_r);
    cur_item.slot_value        = slots_r[idx_r];
    cur_item.all_outputs_off   = ctl_r.all_off;
    cur_item.lease_active_out  = ctl_r.lease;
    cur_item.snapshot_sequence = ctl_r.seq;
    cur_item.reason_code       = ctl_r.reason;
    cur_item.end_of_snapshot   = last;
    cur_item.end_of_item       = last && !ctl_r.twice;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ctl_nxt  = ctl_r;
    if (launch) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      ctl_nxt  = snap_ctl;
    end else if (adv) begin
      if (!last) begin
        idx_nxt = idx_r + 1'b1;
      end else if (ctl_r.twice) begin
        idx_nxt       = '0;
        ctl_nxt.twice = 1'b0;
        ctl_nxt.seq   = ctl_r.seq + 32'd1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (out_load) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ctl_r <= ctl_nxt;
    if (launch) begin
      slots_r <= snap_slots;
    end
    if (out_load) begin
      out_item_r <= cur_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/actuator_lease_failsafe.sv */
// actuator_lease_failsafe: top level, joins the state core and the slot walker
// depends on alf_pkg, alf_core, alf_emit
// path: an item passes the input register, the walker's snapshot copy and the output
//   register; network or ota off sends two snapshots, others one; the walker sends one
//   slot result per cycle unless out stalls and takes the next item with the last slot
// reset: slots zero, lease dropped, reason ready, counter 1, limit 10000 ms
module actuator_lease_failsafe import alf_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic                        emit_free;
  logic                        launch;
  snap_ctl_t                   snap_ctl;
  logic [SLOT_COUNT-1:0][15:0] snap_slots;

  alf_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .emit_free (emit_free),
    .launch    (launch),
    .snap_ctl  (snap_ctl),
    .snap_slots(snap_slots)
  );

  alf_emit #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .launch    (launch),
    .snap_ctl  (snap_ctl),
    .snap_slots(snap_slots),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/alf_checker.sv */
// alf_checker: port-level checks on the result channel of the failsafe
// depends on alf_pkg; bound to actuator_lease_failsafe below
module alf_checker import alf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_item_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_item.end_of_item || out_item.end_of_snapshot)
    else $error("item ended inside a snapshot");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.all_outputs_off |-> out_item.slot_value == 16'sd0)
    else $error("all off flagged with a live slot");

  a_safe_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.reason_code == RSN_NET_OFF ||
                  out_item.reason_code == RSN_OTA_OFF ||
                  out_item.reason_code == RSN_LEASE_LOST)
    |-> !out_item.lease_active_out && out_item.all_outputs_off)
    else $error("switch-off reason with outputs or lease live");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.end_of_snapshot |=> out_valid)
    else $error("gap inside a snapshot");

endmodule

bind actuator_lease_failsafe alf_checker u_alf_checker (.*);

/* verif/testbench.sv */
// testbench: self-checking bench for actuator_lease_failsafe, with its own predictor of
// slots, lease, reason and snapshot counter, and item-by-item result checks
// depends on alf_pkg and the actuator_lease_failsafe rtl
`timescale 1ns / 1ps

module testbench;
  import alf_pkg::*;

  localparam int NSLOTS = SLOT_COUNT_DEF;
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    in_item_t item;
    logic     drain_first;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  pending_t  pending_q[$];
  out_item_t expected_q[$];

  logic signed [15:0] slot_model [NSLOTS];
  logic               lease_model;
  logic [31:0]        last_act_model;
  reason_t            reason_model;
  logic [31:0]        seq_model;
  logic [31:0]        limit_model;

  logic [31:0] clock_ms;
  logic        in_took = 1'b0;
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  actuator_lease_failsafe u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_snapshot(input logic last);
    out_item_t r;
    logic      all_zero;
    all_zero = 1'b1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_model[i] != 16'sd0) all_zero = 1'b0;
    end
    seq_model = seq_model + 32'd1;
    for (int i = 0; i < NSLOTS; i++) begin
      r.slot_index        = i[3:0];
      r.slot_value        = slot_model[i];
      r.all_outputs_off   = all_zero;
      r.lease_active_out  = lease_model;
      r.snapshot_sequence = seq_model;
      r.reason_code       = reason_model;
      r.end_of_snapshot   = (i == NSLOTS - 1);
      r.end_of_item       = last && (i == NSLOTS - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic switch_off(input reason_t why, input logic last);
    reason_model = why;
    for (int i = 0; i < NSLOTS; i++) slot_model[i] = 16'sd0;
    lease_model = 1'b0;
    push_snapshot(last);
  endtask

  task automatic predict_item(input in_item_t it);
    logic [31:0] age;
    logic [31:0] quiet_for;
    age = it.now_ms - it.created_ms;
    if (it.op <= OP_OTA_OFF && age <= it.ttl_ms) begin
      case (it.op)
        OP_SET_OUTPUT: begin
          if (it.target_index < NSLOTS && it.apply_ok) begin
            slot_model[it.target_index] = it.set_value;
            lease_model = 1'b1;
            last_act_model = it.now_ms;
            reason_model = RSN_COMMAND;
          end
        end
        OP_HEARTBEAT: begin
          lease_model = 1'b1;
          last_act_model = it.now_ms;
          reason_model = RSN_HEARTBEAT;
        end
        OP_NETWORK_OFF: switch_off(RSN_NET_OFF, 1'b0);
        default: switch_off(RSN_OTA_OFF, 1'b0);
      endcase
    end
    quiet_for = it.now_ms - last_act_model;
    if (lease_model && quiet_for > limit_model) begin
      switch_off(RSN_LEASE_LOST, 1'b1);
    end else begin
      push_snapshot(1'b1);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with none expected, slot", 32'(got.slot_index), '0);
    end else begin
      want = expected_q.pop_front();
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
      if (got.slot_value !== want.slot_value)
        report_mismatch("slot_value", 32'(got.slot_value), 32'(want.slot_value));
      if (got.all_outputs_off !== want.all_outputs_off)
        report_mismatch("all_outputs_off", 32'(got.all_outputs_off),
                        32'(want.all_outputs_off));
      if (got.lease_active_out !== want.lease_active_out)
        report_mismatch("lease_active_out", 32'(got.lease_active_out),
                        32'(want.lease_active_out));
      if (got.snapshot_sequence !== want.snapshot_sequence)
        report_mismatch("snapshot_sequence", got.snapshot_sequence,
                        want.snapshot_sequence);
      if (got.reason_code !== want.reason_code)
        report_mismatch("reason_code", 32'(got.reason_code), 32'(want.reason_code));
      if (got.end_of_snapshot !== want.end_of_snapshot)
        report_mismatch("end_of_snapshot", 32'(got.end_of_snapshot),
                        32'(want.end_of_snapshot));
      if (got.end_of_item !== want.end_of_item)
        report_mismatch("end_of_item", 32'(got.end_of_item), 32'(want.end_of_item));
    end
  endtask

  // predictor runs on accepted items, checker on accepted results
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_item);
        items_taken++;
      end
      if (out_valid && !out_stall) check_result(out_item);
    end
  end

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_q.size() != 0 && !(pending_q[0].drain_first && expected_q.size() != 0)
          && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_q[0].item;
        in_valid <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic enqueue(input in_item_t it, input logic drain);
    pending_t p;
    p.item = it;
    p.drain_first = drain;
    pending_q.push_back(p);
    items_queued++;
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [31:0] now,
                           input logic [31:0] created, input logic [31:0] ttl,
                           input logic [7:0] target, input logic signed [15:0] value,
                           input logic ok);
    in_item_t it;
    it.op = op;
    it.now_ms = now;
    it.created_ms = created;
    it.ttl_ms = ttl;
    it.target_index = target;
    it.set_value = value;
    it.apply_ok = ok;
    enqueue(it, 1'b0);
  endtask

  // mostly plausible command streams on a moving clock, some pure noise
  task automatic queue_random(input int count, input int drain_at);
    in_item_t it;
    int       pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(9) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(400);
        pick = $urandom_range(99);
        if (pick < 45) it.op = OP_SET_OUTPUT;
        else if (pick < 60) it.op = OP_HEARTBEAT;
        else if (pick < 66) it.op = OP_NETWORK_OFF;
        else if (pick < 72) it.op = OP_OTA_OFF;
        else it.op = OP_IDLE;
        it.now_ms = clock_ms;
        it.created_ms = clock_ms - $urandom_range(150);
        it.ttl_ms = $urandom_range(300);
        if ($urandom_range(7) == 0) it.target_index = 8'($urandom_range(255));
        else it.target_index = 8'($urandom_range(NSLOTS - 1));
        it.set_value = 16'($urandom);
        it.apply_ok = ($urandom_range(15) != 0);
      end else begin
        it.op = 3'($urandom_range(7));
        it.now_ms = $urandom;
        it.created_ms = $urandom;
        it.ttl_ms = $urandom;
        it.target_index = 8'($urandom);
        it.set_value = 16'($urandom);
        it.apply_ok = 1'($urandom);
      end
      enqueue(it, n == drain_at);
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (items_taken != items_queued || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_model = v;
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) slot_model[i] = 16'sd0;
    lease_model = 1'b0;
    last_act_model = '0;
    reason_model = RSN_READY;
    seq_model = SEQ_RST;
    limit_model = LEASE_LIMIT_RST;
    send_idle_pct = 33;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, ttl and lease edges, both switch-offs, reserved ops
    queue_cmd(OP_IDLE, 32'd0, 32'd0, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_SET_OUTPUT, 32'd100, 32'd100, 32'd0, 8'd0, -16'sd32768, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd200, 32'd150, 32'd50, 8'd9, 16'sd32767, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd300, 32'd249, 32'd50, 8'd5, 16'sd1, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd310, 32'd310, 32'd10, 8'd10, 16'sd5, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd320, 32'd320, 32'd10, 8'd255, -16'sd5, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd330, 32'd330, 32'd10, 8'd3, 16'sd7, 1'b0);
    queue_cmd(OP_HEARTBEAT, 32'd400, 32'd400, 32'd0, 8'd0, 16'sd0, 1'b1);
    queue_cmd(OP_HEARTBEAT, 32'd500, 32'd501, 32'hFFFF_FFFF, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_IDLE, 32'd10500, 32'd0, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_IDLE, 32'd10501, 32'd0, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_SET_OUTPUT, 32'd11000, 32'd11000, 32'd0, 8'd4, 16'sh1234, 1'b1);
    queue_cmd(OP_NETWORK_OFF, 32'd11100, 32'd11100, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_SET_OUTPUT, 32'd11200, 32'd11200, 32'd0, 8'd1, -16'sd1, 1'b1);
    queue_cmd(OP_OTA_OFF, 32'd11300, 32'd11300, 32'd0, 8'd0, 16'sd0, 1'b1);
    queue_cmd(OP_RSVD_FIRST, 32'd11400, 32'd11400, 32'd0, 8'd2, 16'sd9, 1'b1);
    queue_cmd(OP_RSVD_FIRST + 3'd1, 32'd11410, 32'd11410, 32'd0, 8'd2, 16'sd9, 1'b1);
    queue_cmd(OP_RSVD_FIRST + 3'd2, 32'd11420, 32'd11420, 32'd0, 8'd2, 16'sd9, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'd11500, 32'd11500, 32'd0, 8'd2, 16'sd99, 1'b1);
    queue_cmd(OP_NETWORK_OFF, 32'd11600, 32'd11000, 32'd10, 8'd0, 16'sd0, 1'b1);
    queue_cmd(OP_OTA_OFF, 32'd11700, 32'd11000, 32'd10, 8'd0, 16'sd0, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'd0, 8'd7, 16'sd3, 1'b1);
    queue_cmd(OP_IDLE, 32'h0000_2000, 32'd0, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_IDLE, 32'h0000_2800, 32'd0, 32'd0, 8'd0, 16'sd0, 1'b0);
    queue_cmd(OP_SET_OUTPUT, 32'h0000_2900, 32'd0, 32'hFFFF_FFFF, 8'd8, 16'sd0, 1'b1);
    queue_cmd(OP_SET_OUTPUT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 8'd6, 16'sd4, 1'b1);
    clock_ms = 32'h0000_3000;

    write_limit(32'd300);
    hold_reqs++;
    queue_random(25, -1);

    write_limit(32'd0);
    send_idle_pct = 79;
    recv_idle_pct = 33;
    queue_random(25, 15);

    write_limit(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(25, -1);

    wait_quiet();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
